@@ sv/xrr_pkg.sv @@
// Package for the xorshift range random block: sequencer states, generator
// control bundle, shift constants and the state advance function.
// No dependencies.
`timescale 1ns / 1ps

package xrr_pkg;

   localparam int unsigned SHIFT_A = 21;
   localparam int unsigned SHIFT_B = 35;
   localparam int unsigned SHIFT_C = 4;

   // Width of the draw counter; a request gives up with an error after 2**TRY_W draws.
   localparam int unsigned TRY_W = 20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_LOAD,
      ST_DIVIDE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic step;
      logic reload;
   } gen_ctrl_type;

   // One xorshift step; the middle shift replicates the sign bit.
   function automatic logic [63:0] xrr_advance(input logic [63:0] s_in);
      logic [63:0] s;
      s = s_in;
      s = s ^ (s << SHIFT_A);
      s = s ^ 64'($unsigned($signed(s) >>> SHIFT_B));
      s = s ^ (s << SHIFT_C);
      return s;
   endfunction

endpackage

@@ sv/xrr_gen.sv @@
// Generator state for the xorshift range random block: seed register,
// initialized flag and the 64-bit xorshift state. Uses xrr_pkg.
`timescale 1ns / 1ps

module xrr_gen
   import xrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [63:0]  csr_wdata,
   input  gen_ctrl_type ctrl,
   output logic [31:0]  draw_bits
);

   logic [63:0] seed_ff, seed_in;
   logic        init_ff, init_in;
   logic [63:0] state_ff, state_in;

   always_comb begin
      seed_in  = seed_ff;
      init_in  = init_ff;
      state_in = state_ff;
      if (csr_we) begin
         seed_in = csr_wdata;
         init_in = 1'b0;
      end else if (ctrl.step) begin
         // A reload request or an uninitialized generator starts from the seed.
         if (ctrl.reload || !init_ff) begin
            state_in = xrr_advance(seed_ff);
         end else begin
            state_in = xrr_advance(state_ff);
         end
         init_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 64'd1;
         init_ff  <= 1'b0;
         state_ff <= 64'd0;
      end else begin
         seed_ff  <= seed_in;
         init_ff  <= init_in;
         state_ff <= state_in;
      end
   end

   assign draw_bits = state_ff[31:0];

endmodule

@@ sv/xrr_rem.sv @@
// Restoring remainder unit, one quotient bit per cycle for a 32-bit dividend.
// Uses xrr_pkg only for the house import.
`timescale 1ns / 1ps

module xrr_rem
   import xrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [30:0] remainder
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [31:0] trial;

   // The divisor is at most 2^31, so the remainder always fits 31 bits and
   // the shifted trial value fits 32.
   assign trial = {rem_ff[30:0], dvd_ff[31]};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = 32'd0;
         dvd_in  = dividend;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (trial >= divisor) ? (trial - divisor) : trial;
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = busy_ff && (cnt_ff == 5'd31);
   assign remainder = rem_ff[30:0];

endmodule

@@ sv/xorshift_range_random_top.sv @@
// Each draw steps the generator, loads the remainder unit, runs its 32 remainder steps
// and checks the result; a rejected draw starts another, and a minimum beyond the range
// goes from idle straight to finish, which returns to idle once the result register is free.
// The 32-step remainder unit sets the pace of each draw; one request is in flight.
// Synchronous active-high reset: seed 1, generator state 0, not initialized.
// Top level of the xorshift range random block; uses xrr_pkg, xrr_gen, xrr_rem.
`timescale 1ns / 1ps

module xorshift_range_random_top
   import xrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] range_min, [63:32] range_max
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] value, [31] zero fill
   output logic        rsp_tuser    // [0] range_error
);

   state_type state_ff, state_in;

   logic [30:0]      lo_ff;
   logic [31:0]      mod_ff;
   logic             reload_ff;
   logic [TRY_W-1:0] tries_ff;
   logic [30:0]      res_value_ff;
   logic             res_err_ff;
   logic             rsp_valid_ff;
   logic [30:0]      rsp_value_ff;
   logic             rsp_err_ff;

   logic         accept;
   logic         out_free;
   logic         div_start;
   logic         div_done;
   logic [30:0]  rem;
   logic [31:0]  draw_bits;
   logic [31:0]  dividend;
   gen_ctrl_type gen_ctrl;

   logic signed [31:0] req_min;
   logic signed [31:0] req_max;
   logic [30:0]        lo_clamped;
   logic [31:0]        mod_req;
   logic               out_of_range;
   logic               hit;

   assign req_min = req_tdata[31:0];
   assign req_max = req_tdata[63:32];

   // Negative minimum clamps to zero; a maximum below zero gives modulus one.
   assign lo_clamped   = req_min[31] ? 31'd0 : req_min[30:0];
   assign mod_req      = req_max[31] ? 32'd1 : ({1'b0, req_max[30:0]} + 32'd1);
   assign out_of_range = {1'b0, lo_clamped} >= mod_req;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // C remainder magnitude equals the unsigned remainder of the magnitude.
   assign dividend = draw_bits[31] ? (32'd0 - draw_bits) : draw_bits;
   assign hit      = rem >= lo_ff;

   xrr_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctrl      (gen_ctrl),
      .draw_bits (draw_bits)
   );

   xrr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (mod_ff),
      .done      (div_done),
      .remainder (rem)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = out_of_range ? ST_FINISH : ST_DRAW;
            end
         end
         ST_DRAW:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (hit || (tries_ff == {TRY_W{1'b1}})) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DRAW;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      div_start       = 1'b0;
      gen_ctrl.step   = 1'b0;
      gen_ctrl.reload = reload_ff;
      case (state_ff)
         ST_IDLE:  req_tready    = 1'b1;
         ST_DRAW:  gen_ctrl.step = 1'b1;
         ST_LOAD:  div_start     = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         lo_ff        <= lo_clamped;
         mod_ff       <= mod_req;
         reload_ff    <= req_max == -32'sd1;
         tries_ff     <= '0;
         res_value_ff <= 31'd0;
         res_err_ff   <= out_of_range;
      end
      if (state_ff == ST_CHECK) begin
         if (hit) begin
            res_value_ff <= rem;
            res_err_ff   <= 1'b0;
         end else if (tries_ff == {TRY_W{1'b1}}) begin
            res_value_ff <= 31'd0;
            res_err_ff   <= 1'b1;
         end else begin
            tries_ff <= tries_ff + TRY_W'(1);
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_value_ff <= res_value_ff;
         rsp_err_ff   <= res_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

@@ sv/xrr_checker.sv @@
// Port-level checker for the xorshift range random block, with its bind.
// Depends on xorshift_range_random_top and xrr_pkg.
`timescale 1ns / 1ps

module xrr_checker
   import xrr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // An error result always carries a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("error result with nonzero value");

   // Only one request is in flight: acceptance closes the request side.
   a_one_open: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind xorshift_range_random_top xrr_checker u_xrr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
